/* src/bank_aware_bump_allocator_defines.svh */
// Assertion macros for the allocator's checker file.
`ifndef BANK_AWARE_BUMP_ALLOCATOR_DEFINES_SVH
`define BANK_AWARE_BUMP_ALLOCATOR_DEFINES_SVH

// Property checked at every edge, reset included
`define BBA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bba assertion failed");

// Same-cycle implication, off while reset is high
`define BBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bba assertion failed");

// Next-cycle implication, off while reset is high
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bba assertion failed");

`endif

/* src/bba_pkg.sv */
// Types, widths and codes shared by the bump allocator files.
package bba_pkg;

  // Bank geometry
  localparam int BANK_BITS = 16;

  // Field widths
  localparam int OP_W   = 3;
  localparam int REQ_W  = 32;
  localparam int NB_W   = 16;
  localparam int CUR_W  = 25;
  localparam int ADDR_W = 24;
  localparam int CNT_W  = 16;
  localparam int CFG_W  = 8;

  // Working width for sums: covers a rounded 32-bit request and a whole-bank span
  localparam int SUM_W = ((NB_W + BANK_BITS + 1) > (REQ_W + 2)) ?
                         (NB_W + BANK_BITS + 1) : (REQ_W + 2);

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int IDX_W   = PADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_FIRST_BANK = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_LAST_BANK  = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_BANK_COUNT = IDX_W'(2);

  // Opcodes
  localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OP_W-1:0] OP_SPAN    = 3'd1;
  localparam logic [OP_W-1:0] OP_BANKS   = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK    = 3'd3;
  localparam logic [OP_W-1:0] OP_RELEASE = 3'd4;
  localparam logic [OP_W-1:0] OP_FOOT    = 3'd5;

  typedef struct packed {
    logic [CFG_W-1:0] foot_bank;
    logic [CFG_W-1:0] top_bank;
    logic [CFG_W-1:0] bank_count;
  } cfg_t;

  typedef struct packed {
    logic [CUR_W-1:0] cursor;
    logic [CUR_W-1:0] floor_mark;
    logic [CNT_W-1:0] refusals;
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [REQ_W-1:0] request_bytes;
    logic [NB_W-1:0]  bank_count;
    logic [CUR_W-1:0] release_mark;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic              release_refused;
    logic [CNT_W-1:0]  refusal_count;
    logic [CUR_W-1:0]  cursor_now;
  } res_t;

endpackage

/* src/bba_step.sv */
// Allocator datapath: next cursor, floor, refusal count and result for one item.
module bba_step (
  input  bba_pkg::cfg_t   cfg,
  input  bba_pkg::state_t state,
  input  bba_pkg::req_t   req,
  output bba_pkg::state_t state_next,
  output bba_pkg::res_t   res
);
  import bba_pkg::*;

  localparam logic [SUM_W-1:0] BANK_SIZE = SUM_W'(1) << BANK_BITS;
  localparam logic [SUM_W-1:0] BANK_MASK = BANK_SIZE - SUM_W'(1);
  localparam logic [SUM_W-1:0] ADDR_CEIL = SUM_W'(1) << ADDR_W;

  logic [SUM_W-1:0] end_raw;
  logic [SUM_W-1:0] heap_end;
  logic [SUM_W-1:0] foot_raw;
  logic [SUM_W-1:0] heap_foot;
  logic [SUM_W-1:0] cur_w;
  logic [SUM_W-1:0] size_rnd;
  logic [SUM_W-1:0] bank_top;
  logic [SUM_W-1:0] blk_base;
  logic [SUM_W-1:0] byte_base;
  logic [SUM_W-1:0] byte_end;
  logic [SUM_W-1:0] bank_base;
  logic [SUM_W-1:0] bank_num;
  logic [SUM_W-1:0] bank_span;
  logic [SUM_W-1:0] bank_stop;
  logic             heap_live;
  logic             too_big;
  logic             byte_ok;
  logic             bank_ok;

  // Heap limits, saturated at the top of the address space
  always_comb begin
    end_raw   = (SUM_W'(cfg.top_bank) + SUM_W'(1)) << BANK_BITS;
    heap_end  = (end_raw > ADDR_CEIL) ? ADDR_CEIL : end_raw;
    foot_raw  = SUM_W'(cfg.foot_bank) << BANK_BITS;
    heap_foot = (foot_raw > ADDR_CEIL) ? ADDR_CEIL : foot_raw;
    heap_live = (cfg.bank_count != '0);
  end

  // Byte allocation: round to 4; for OP_ALLOC, hop to the next bank if a block would straddle
  always_comb begin
    cur_w     = SUM_W'(state.cursor);
    size_rnd  = (SUM_W'(req.request_bytes) + SUM_W'(3)) & ~SUM_W'(3);
    bank_top  = (cur_w | BANK_MASK) + SUM_W'(1);
    blk_base  = ((cur_w + size_rnd) > bank_top) ? bank_top : cur_w;
    byte_base = (req.opcode == OP_ALLOC) ? blk_base : cur_w;
    too_big   = (req.opcode == OP_ALLOC) && (size_rnd > BANK_SIZE);
    byte_end  = byte_base + size_rnd;
    byte_ok   = heap_live && (req.request_bytes != '0) && !too_big &&
                (byte_end <= heap_end);
  end

  // Whole-bank allocation from the next bank boundary
  always_comb begin
    bank_base = (cur_w + BANK_MASK) & ~BANK_MASK;
    bank_num  = bank_base >> BANK_BITS;
    bank_span = SUM_W'(req.bank_count) << BANK_BITS;
    bank_stop = bank_base + bank_span;
    bank_ok   = heap_live && (req.bank_count != '0) && (bank_stop <= heap_end);
  end

  // Opcode selection
  always_comb begin
    state_next          = state;
    res.result_address  = '0;
    res.release_refused = 1'b0;
    case (req.opcode)
      OP_ALLOC, OP_SPAN: begin
        if (byte_ok) begin
          state_next.cursor  = byte_end[CUR_W-1:0];
          res.result_address = byte_base[ADDR_W-1:0];
        end
      end
      OP_BANKS: begin
        if (bank_ok) begin
          state_next.cursor  = bank_stop[CUR_W-1:0];
          res.result_address = bank_num[ADDR_W-1:0];
        end
      end
      OP_MARK: begin
        state_next.floor_mark = state.cursor;
      end
      OP_RELEASE: begin
        if (req.release_mark < state.floor_mark) begin
          res.release_refused = 1'b1;
          state_next.refusals = state.refusals + CNT_W'(1);
        end else begin
          state_next.cursor = req.release_mark;
        end
      end
      OP_FOOT: begin
        state_next.cursor = heap_foot[CUR_W-1:0];
      end
      default: begin
      end
    endcase
    res.refusal_count = state_next.refusals;
    res.cursor_now    = state_next.cursor;
  end

endmodule

/* src/bank_aware_bump_allocator.sv */
// Bump allocator over a run of banks: one item a cycle while results are taken, one result per item.
// An accepted item is held in the input register, then moves on to the result register.
// Throughput: one item per cycle unless the result register stalls; the cursor is updated as each result is registered.
// The input stage only stalls while the result register is full and not taken.
// Synchronous reset clears cursor, floor mark, refusal count, config and both stages.
module bank_aware_bump_allocator (
  input  logic                          clk,
  input  logic                          rst,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bba_pkg::PADDR_W-1:0]   paddr,
  input  logic [bba_pkg::PDATA_W-1:0]   pwdata,
  output logic [bba_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // request channel
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [bba_pkg::OP_W-1:0]      opcode,
  input  logic [bba_pkg::REQ_W-1:0]     request_bytes,
  input  logic [bba_pkg::NB_W-1:0]      bank_count,
  input  logic [bba_pkg::CUR_W-1:0]     release_mark,
  // result channel
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [bba_pkg::ADDR_W-1:0]    result_address,
  output logic                          release_refused,
  output logic [bba_pkg::CNT_W-1:0]     refusal_count,
  output logic [bba_pkg::CUR_W-1:0]     cursor_now
);
  import bba_pkg::*;

  cfg_t             cfg;
  state_t           state;
  state_t           state_next;
  req_t             req_q;
  logic             in_full;
  res_t             res_next;
  res_t             res_q;
  logic             advance;
  logic [IDX_W-1:0] reg_idx;

  // Handshake control
  assign advance   = in_full && (!res_valid || res_ready);
  assign req_ready = !in_full || advance;
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];

  // Input register payload
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q.opcode        <= opcode;
      req_q.request_bytes <= request_bytes;
      req_q.bank_count    <= bank_count;
      req_q.release_mark  <= release_mark;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res_next;
    end
  end

  // Stage occupancy, allocator state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      res_valid <= 1'b0;
      state     <= '0;
      cfg       <= '0;
    end else begin
      if (req_valid && req_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
        state     <= state_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx)
          REG_FIRST_BANK: cfg.foot_bank  <= pwdata[CFG_W-1:0];
          REG_LAST_BANK:  cfg.top_bank   <= pwdata[CFG_W-1:0];
          REG_BANK_COUNT: cfg.bank_count <= pwdata[CFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_FIRST_BANK: prdata = PDATA_W'(cfg.foot_bank);
      REG_LAST_BANK:  prdata = PDATA_W'(cfg.top_bank);
      REG_BANK_COUNT: prdata = PDATA_W'(cfg.bank_count);
      default:        prdata = '0;
    endcase
  end

  bba_step u_step (
    .cfg        (cfg),
    .state      (state),
    .req        (req_q),
    .state_next (state_next),
    .res        (res_next)
  );

  // Result fields
  assign result_address  = res_q.result_address;
  assign release_refused = res_q.release_refused;
  assign refusal_count   = res_q.refusal_count;
  assign cursor_now      = res_q.cursor_now;

endmodule

/* src/bba_checker.sv */
// Port-level checks on the bump allocator, bound to its top level.
`include "bank_aware_bump_allocator_defines.svh"

module bba_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        res_valid,
  input logic                        res_ready,
  input logic [bba_pkg::ADDR_W-1:0]  result_address,
  input logic                        release_refused,
  input logic [bba_pkg::CUR_W-1:0]   cursor_now
);
  import bba_pkg::*;

  // No stale result survives reset
  `BBA_ASSERT_ALWAYS(a_reset_empties, rst |=> !res_valid)

  // A refused release never hands out an address
  `BBA_ASSERT_NOW(a_refused_no_addr, res_valid && release_refused, result_address == '0)

  // Requests are only held off behind a stalled result
  `BBA_ASSERT_NOW(a_stall_cause, !req_ready, res_valid && !res_ready)

  // A stalled item keeps its fields
  `BBA_ASSERT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(result_address) && $stable(cursor_now))

endmodule

bind bank_aware_bump_allocator bba_checker u_bba_checker (.*);
